@@ src/ddcb_pkg.sv @@
// Shared constants, types and codes for the DMA descriptor chain builder.
package ddcb_pkg;

  // Descriptor store geometry
  localparam int DESCS_PER_PAGE = 204;
  localparam int DESC_PAGES     = 4;
  localparam int DESC_BYTES     = 20;
  localparam int PAGE_BYTES     = 4096;
  localparam int PAGE_IDX_W     = 2;
  localparam int SLOT_OFS_W     = 12;

  // Byte offset of the first slot past the end of a descriptor page
  localparam logic [SLOT_OFS_W-1:0] PAGE_FULL_OFS = SLOT_OFS_W'(DESCS_PER_PAGE * DESC_BYTES);
  localparam logic [SLOT_OFS_W-1:0] DESC_STEP     = SLOT_OFS_W'(DESC_BYTES);
  localparam logic [63:0]           PAGE_STEP     = 64'(PAGE_BYTES);

  // Descriptor word flag values
  localparam logic [31:0] SIZE_WORD  = 32'(PAGE_BYTES) | 32'd7;
  localparam logic [63:0] ADDR_FLAGS = 64'd7;
  localparam logic [63:0] NEXT_FLAG  = 64'd2;
  localparam logic [63:0] NEXT_END   = 64'd3;
  localparam logic [63:0] NEXT_OVF   = 64'd2;

  // Result status codes
  localparam logic ST_DESC = 1'b0;
  localparam logic ST_OVERFLOW = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LOOP_MODE,
    CFG_PAGES_IN_USE,
    CFG_BASE_0,
    CFG_BASE_1,
    CFG_BASE_2,
    CFG_BASE_3
  } cfg_idx_t;

  typedef struct packed {
    logic                         loop_mode;
    logic [2:0]                   pages_in_use;
    logic [DESC_PAGES-1:0][63:0]  base;
  } cfg_t;

  typedef struct packed {
    logic [63:0] block_addr;
    logic [5:0]  page_count;
    logic        last_block;
  } item_t;

  // Queue entry: the item plus its classification
  typedef struct packed {
    logic  no_pages;
    item_t item;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } head_t;

  localparam int QDEPTH  = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_PAGE,
    SEQ_OVF,
    SEQ_CLOSE
  } seq_state_t;

endpackage

@@ src/ddcb_ifs.sv @@
// Channel interfaces for block list input and descriptor output.
interface ddcb_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_addr;
  logic [5:0]  page_count;
  logic        last_block;

  modport source(output valid, block_addr, page_count, last_block, input ready);
  modport sink(input valid, block_addr, page_count, last_block, output ready);
endinterface

interface ddcb_desc_if;
  logic        valid;
  logic        ready;
  logic [63:0] desc_location;
  logic [63:0] addr_word;
  logic [31:0] size_word;
  logic [63:0] next_word;
  logic        status;
  logic        end_of_run;

  modport source(output valid, desc_location, addr_word, size_word, next_word, status,
                 end_of_run, input ready);
  modport sink(input valid, desc_location, addr_word, size_word, next_word, status,
               end_of_run, output ready);
endinterface

@@ src/ddcb_front.sv @@
// Front end: accepts block items, classifies them and queues them for the sequencer.
module ddcb_front (
  input  logic            clk,
  input  logic            rst,
  ddcb_block_if.sink      blocks,
  input  logic            pop,
  output ddcb_pkg::head_t head
);

  ddcb_pkg::qent_t                q [ddcb_pkg::QDEPTH];
  logic [ddcb_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [ddcb_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [ddcb_pkg::Q_CNT_W-1:0]   count;
  logic                           push;
  logic                           do_pop;
  ddcb_pkg::qent_t                ent_in;

  assign blocks.ready = (count != ddcb_pkg::Q_CNT_W'(ddcb_pkg::QDEPTH));
  assign push         = blocks.valid && blocks.ready;
  assign do_pop       = pop && (count != '0);

  // Classify on entry: an item with no pages only closes or skips
  always_comb begin
    ent_in.item.block_addr = blocks.block_addr;
    ent_in.item.page_count = blocks.page_count;
    ent_in.item.last_block = blocks.last_block;
    ent_in.no_pages        = (blocks.page_count == '0);
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= ent_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.ent   = q[rd_ptr];

endmodule

@@ src/ddcb_back.sv @@
// Back end: walks the pages of each queued block and emits the linked descriptors.
module ddcb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ddcb_pkg::cfg_t       cfg,
  input  ddcb_pkg::head_t      head,
  output logic                 pop,
  ddcb_desc_if.source          descs
);

  ddcb_pkg::seq_state_t                 state, state_next;
  logic                                 held_valid, held_valid_next;
  logic [63:0]                          held_loc, held_loc_next;
  logic [63:0]                          held_addr, held_addr_next;
  logic [ddcb_pkg::PAGE_IDX_W-1:0]      pidx, pidx_next;
  logic [ddcb_pkg::SLOT_OFS_W-1:0]      slot_ofs, slot_ofs_next;
  logic                                 halted, halted_next;
  logic [5:0]                           pg, pg_next;
  logic [63:0]                          cur_addr, cur_addr_next;

  // Output register
  logic        o_valid, o_valid_next;
  logic [63:0] o_loc, o_aw, o_nw;
  logic [31:0] o_sw;
  logic        o_st, o_end;

  // Result to load this cycle
  logic        emit;
  logic [63:0] e_loc, e_aw, e_nw;
  logic [31:0] e_sw;
  logic        e_st, e_end;

  logic                             ok;
  logic [2:0]                       usable;
  logic                             at_full;
  logic                             no_room;
  logic [ddcb_pkg::PAGE_IDX_W-1:0]  pidx_adv;
  logic [ddcb_pkg::SLOT_OFS_W-1:0]  slot_adv;
  logic [63:0]                      loc;
  logic [5:0]                       pg_inc;
  logic                             last_pg;
  logic                             last;

  assign ok   = !o_valid || descs.ready;
  assign last = head.ent.item.last_block;

  // Usable descriptor pages, clamped to one..DESC_PAGES
  always_comb begin
    if (cfg.pages_in_use == 3'd0) begin
      usable = 3'd1;
    end else if (cfg.pages_in_use > 3'(ddcb_pkg::DESC_PAGES)) begin
      usable = 3'(ddcb_pkg::DESC_PAGES);
    end else begin
      usable = cfg.pages_in_use;
    end
  end

  // Slot placement for the next descriptor
  assign at_full  = (slot_ofs == ddcb_pkg::PAGE_FULL_OFS);
  assign no_room  = at_full && (({1'b0, pidx} + 3'd1) >= usable);
  assign pidx_adv = at_full ? pidx + 1'b1 : pidx;
  assign slot_adv = at_full ? '0 : slot_ofs;
  assign loc      = cfg.base[pidx_adv] + {{(64 - ddcb_pkg::SLOT_OFS_W){1'b0}}, slot_adv};
  assign pg_inc   = pg + 6'd1;
  assign last_pg  = (pg_inc == head.ent.item.page_count);

  // Sequencer next state and results
  always_comb begin
    state_next      = state;
    held_valid_next = held_valid;
    held_loc_next   = held_loc;
    held_addr_next  = held_addr;
    pidx_next       = pidx;
    slot_ofs_next   = slot_ofs;
    halted_next     = halted;
    pg_next         = pg;
    cur_addr_next   = cur_addr;
    pop             = 1'b0;
    emit            = 1'b0;
    e_loc           = held_loc;
    e_aw            = held_addr | ddcb_pkg::ADDR_FLAGS;
    e_sw            = ddcb_pkg::SIZE_WORD;
    e_nw            = ddcb_pkg::NEXT_OVF;
    e_st            = ddcb_pkg::ST_DESC;
    e_end           = 1'b0;

    case (state)
      ddcb_pkg::SEQ_IDLE: begin
        if (head.valid) begin
          if (halted) begin
            pop = 1'b1;
            if (last) begin
              held_valid_next = 1'b0;
              pidx_next       = '0;
              slot_ofs_next   = '0;
              halted_next     = 1'b0;
            end
          end else if (head.ent.no_pages) begin
            if (last && held_valid) begin
              state_next = ddcb_pkg::SEQ_CLOSE;
            end else begin
              pop = 1'b1;
              if (last) begin
                held_valid_next = 1'b0;
                pidx_next       = '0;
                slot_ofs_next   = '0;
              end
            end
          end else begin
            cur_addr_next = head.ent.item.block_addr;
            pg_next       = '0;
            state_next    = ddcb_pkg::SEQ_PAGE;
          end
        end
      end

      ddcb_pkg::SEQ_PAGE: begin
        if (ok) begin
          if (no_room) begin
            if (held_valid) begin
              // Close the held descriptor, overflow result goes next
              emit            = 1'b1;
              e_nw            = ddcb_pkg::NEXT_OVF;
              held_valid_next = 1'b0;
              state_next      = ddcb_pkg::SEQ_OVF;
            end else begin
              emit        = 1'b1;
              e_loc       = '0;
              e_aw        = '0;
              e_sw        = '0;
              e_nw        = '0;
              e_st        = ddcb_pkg::ST_OVERFLOW;
              e_end       = 1'b1;
              halted_next = 1'b1;
              pop         = 1'b1;
              state_next  = ddcb_pkg::SEQ_IDLE;
              if (last) begin
                pidx_next     = '0;
                slot_ofs_next = '0;
                halted_next   = 1'b0;
              end
            end
          end else begin
            // Link the held descriptor to this one, then hold this one
            if (held_valid) begin
              emit  = 1'b1;
              e_nw  = loc | ddcb_pkg::NEXT_FLAG;
              e_end = last_pg && !last;
            end
            held_valid_next = 1'b1;
            held_loc_next   = loc;
            held_addr_next  = cur_addr;
            pidx_next       = pidx_adv;
            slot_ofs_next   = slot_adv + ddcb_pkg::DESC_STEP;
            cur_addr_next   = cur_addr + ddcb_pkg::PAGE_STEP;
            pg_next         = pg_inc;
            if (last_pg) begin
              if (last) begin
                state_next = ddcb_pkg::SEQ_CLOSE;
              end else begin
                pop        = 1'b1;
                state_next = ddcb_pkg::SEQ_IDLE;
              end
            end
          end
        end
      end

      ddcb_pkg::SEQ_OVF: begin
        if (ok) begin
          emit        = 1'b1;
          e_loc       = '0;
          e_aw        = '0;
          e_sw        = '0;
          e_nw        = '0;
          e_st        = ddcb_pkg::ST_OVERFLOW;
          e_end       = 1'b1;
          halted_next = 1'b1;
          pop         = 1'b1;
          state_next  = ddcb_pkg::SEQ_IDLE;
          if (last) begin
            pidx_next     = '0;
            slot_ofs_next = '0;
            halted_next   = 1'b0;
          end
        end
      end

      ddcb_pkg::SEQ_CLOSE: begin
        if (ok) begin
          emit            = 1'b1;
          e_nw            = cfg.loop_mode ? (cfg.base[0] | ddcb_pkg::NEXT_FLAG)
                                          : ddcb_pkg::NEXT_END;
          e_end           = 1'b1;
          held_valid_next = 1'b0;
          pidx_next       = '0;
          slot_ofs_next   = '0;
          halted_next     = 1'b0;
          pop             = 1'b1;
          state_next      = ddcb_pkg::SEQ_IDLE;
        end
      end

      default: begin
        state_next = ddcb_pkg::SEQ_IDLE;
      end
    endcase

    if (emit) begin
      o_valid_next = 1'b1;
    end else if (descs.ready) begin
      o_valid_next = 1'b0;
    end else begin
      o_valid_next = o_valid;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ddcb_pkg::SEQ_IDLE;
      held_valid <= 1'b0;
      pidx       <= '0;
      slot_ofs   <= '0;
      halted     <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      held_valid <= held_valid_next;
      pidx       <= pidx_next;
      slot_ofs   <= slot_ofs_next;
      halted     <= halted_next;
      o_valid    <= o_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_loc  <= held_loc_next;
    held_addr <= held_addr_next;
    pg        <= pg_next;
    cur_addr  <= cur_addr_next;
    if (emit) begin
      o_loc <= e_loc;
      o_aw  <= e_aw;
      o_sw  <= e_sw;
      o_nw  <= e_nw;
      o_st  <= e_st;
      o_end <= e_end;
    end
  end

  assign descs.valid         = o_valid;
  assign descs.desc_location = o_loc;
  assign descs.addr_word     = o_aw;
  assign descs.size_word     = o_sw;
  assign descs.next_word     = o_nw;
  assign descs.status        = o_st;
  assign descs.end_of_run    = o_end;

endmodule

@@ src/dma_descriptor_chain_builder.sv @@
// Top level: configuration registers, block queue and descriptor sequencer.
// Flow: an accepted block is registered in the queue; after a setup step in the idle state each
//   page is placed in the page state, its descriptor appearing when the following page is placed.
// Throughput: one page per cycle while the output can take a result; the close and overflow
//   results have states of their own; halted blocks, and empty ones closing no chain, pop from idle.
// Reset (synchronous, rst high) empties the queue, clears the chain and loads register
//   defaults: loop mode on, four descriptor pages, all page bases zero.
module dma_descriptor_chain_builder (
  input  logic        clk,
  input  logic        rst,
  ddcb_block_if.sink  blocks,
  ddcb_desc_if.source descs,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  ddcb_pkg::cfg_t  cfg;
  ddcb_pkg::head_t head;
  logic            pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode    <= 1'b1;
      cfg.pages_in_use <= 3'(ddcb_pkg::DESC_PAGES);
      cfg.base         <= '0;
    end else if (cfg_we) begin
      case (ddcb_pkg::cfg_idx_t'(cfg_index))
        ddcb_pkg::CFG_LOOP_MODE:    cfg.loop_mode    <= cfg_data[0];
        ddcb_pkg::CFG_PAGES_IN_USE: cfg.pages_in_use <= cfg_data[2:0];
        ddcb_pkg::CFG_BASE_0:       cfg.base[0]      <= cfg_data;
        ddcb_pkg::CFG_BASE_1:       cfg.base[1]      <= cfg_data;
        ddcb_pkg::CFG_BASE_2:       cfg.base[2]      <= cfg_data;
        ddcb_pkg::CFG_BASE_3:       cfg.base[3]      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ddcb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .blocks (blocks),
    .pop    (pop),
    .head   (head)
  );

  ddcb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .pop   (pop),
    .descs (descs)
  );

`ifndef SYNTHESIS
  // Overflow results carry zero words and always end the run
  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    descs.valid && (descs.status == ddcb_pkg::ST_OVERFLOW) |->
      (descs.next_word == '0) && (descs.addr_word == '0) && descs.end_of_run)
    else $error("overflow result not well formed");

  // Descriptor results carry flagged address, size and next words
  a_desc_words: assert property (@(posedge clk) disable iff (rst)
    descs.valid && (descs.status == ddcb_pkg::ST_DESC) |->
      (descs.addr_word[2:0] == 3'b111) && (descs.size_word == ddcb_pkg::SIZE_WORD) &&
      descs.next_word[1])
    else $error("descriptor words missing flags");

  // The sequencer never pops an empty queue
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue popped while empty");
`endif

endmodule
